// ----- hdl/assert_macros.svh -----
// assertion macros shared by the transposition table modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk and disabled during rst
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// condition that must never hold
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ----- hdl/tt_pkg.sv -----
// types and constants of the transposition table
package tt_pkg;

  localparam int ACT_W   = 2;
  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 8;
  localparam int SCORE_W = 16;
  localparam int BOUND_W = 2;
  localparam int SQ_W    = 6;

  localparam logic [ACT_W-1:0] ACT_PROBE_SCORE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SAVE        = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PROBE_MOVE  = 2'd2;

  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
  localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
  localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;

  // key reduction for table sizes that are not a power of two
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = KEY_W / MOD_BITS;
  localparam int MOD_CNT_W = 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [KEY_W-1:0]   key;
    logic [DEPTH_W-1:0] depth;
    logic [SCORE_W-1:0] alpha;
    logic [SCORE_W-1:0] beta;
    logic [SCORE_W-1:0] score;
    logic [BOUND_W-1:0] bound;
    logic [SQ_W-1:0]    from_sq;
    logic [SQ_W-1:0]    to_sq;
  } req_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   tag;
    logic [DEPTH_W-1:0] depth;
    logic [BOUND_W-1:0] bound;
    logic [SCORE_W-1:0] score;
    logic [SQ_W-1:0]    from_sq;
    logic [SQ_W-1:0]    to_sq;
  } entry_t;

  typedef struct packed {
    logic               score_found;
    logic [SCORE_W-1:0] found_score;
    logic               move_matches;
  } res_t;

endpackage

// ----- hdl/tt_front.sv -----
// front end: takes a request and reduces its key to a table index
module tt_front #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int IDX_W = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  tt_pkg::req_t      in_req,
  output logic              front_ready,
  output logic              push_valid,
  output tt_pkg::req_t      push_req,
  output logic [IDX_W-1:0]  push_idx,
  input  logic              push_ready
);

  localparam bit POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam int RW = IDX_W + 1;

  logic                          held;
  logic                          mod_done;
  tt_pkg::req_t                  req;
  logic [IDX_W-1:0]              idx;
  logic [IDX_W-1:0]              idx_next;
  logic [tt_pkg::KEY_W-1:0]      keysh;
  logic [tt_pkg::MOD_CNT_W-1:0]  cnt;
  logic [RW-1:0]                 r;

  assign push_valid  = held && mod_done;
  assign push_req    = req;
  assign push_idx    = idx;
  assign front_ready = !held || (mod_done && push_ready);

  // restoring reduction, a few key bits per cycle
  always_comb begin
    r = {1'b0, idx};
    for (int j = 0; j < tt_pkg::MOD_BITS; j++) begin
      r = {r[RW-2:0], keysh[tt_pkg::KEY_W-1-j]};
      if (r >= RW'(TABLE_ENTRIES)) r = r - RW'(TABLE_ENTRIES);
    end
    idx_next = r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= 1'b0;
      mod_done <= 1'b0;
    end else if (accept) begin
      held  <= 1'b1;
      req   <= in_req;
      keysh <= in_req.key;
      cnt   <= '0;
      if (POW2) begin
        idx      <= in_req.key[IDX_W-1:0] & IDX_W'(TABLE_ENTRIES - 1);
        mod_done <= 1'b1;
      end else begin
        idx      <= '0;
        mod_done <= 1'b0;
      end
    end else if (push_valid && push_ready) begin
      held     <= 1'b0;
      mod_done <= 1'b0;
    end else if (held && !mod_done) begin
      idx   <= idx_next;
      keysh <= {keysh[tt_pkg::KEY_W-tt_pkg::MOD_BITS-1:0], {tt_pkg::MOD_BITS{1'b0}}};
      cnt   <= cnt + 1'b1;
      if (cnt == tt_pkg::MOD_CNT_W'(tt_pkg::MOD_STEPS - 1)) mod_done <= 1'b1;
    end
  end

endmodule

// ----- hdl/tt_queue.sv -----
// short request queue between front and back end
`include "assert_macros.svh"

module tt_queue #(
  parameter int IDX_W = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  tt_pkg::req_t      push_req,
  input  logic [IDX_W-1:0]  push_idx,
  output logic              push_ready,
  input  logic              pop,
  output logic              head_valid,
  output tt_pkg::req_t      head_req,
  output logic [IDX_W-1:0]  head_idx
);

  tt_pkg::req_t               q_req [tt_pkg::QUEUE_DEPTH];
  logic [IDX_W-1:0]           q_idx [tt_pkg::QUEUE_DEPTH];
  logic [tt_pkg::QPTR_W-1:0]  wr_ptr;
  logic [tt_pkg::QPTR_W-1:0]  rd_ptr;
  logic [tt_pkg::QCNT_W-1:0]  count;
  logic                       push_fire;
  logic                       pop_fire;

  assign push_ready = count != tt_pkg::QCNT_W'(tt_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_req   = q_req[rd_ptr];
  assign head_idx   = q_idx[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      q_req[wr_ptr] <= push_req;
      q_idx[wr_ptr] <= push_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) wr_ptr <= wr_ptr + 1'b1;
      if (pop_fire) rd_ptr <= rd_ptr + 1'b1;
      if (push_fire && !pop_fire) count <= count + 1'b1;
      else if (pop_fire && !push_fire) count <= count - 1'b1;
    end
  end

  `ASSERT_NEXT(q_fill_a, push_fire && !pop_fire, count == $past(count) + 2'd1)

endmodule

// ----- hdl/tt_back.sv -----
// back end: table memory, clearing pass, save and probe evaluation
`include "assert_macros.svh"

module tt_back #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int IDX_W = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  tt_pkg::req_t      head_req,
  input  logic [IDX_W-1:0]  head_idx,
  output logic              pop,
  output logic              clearing,
  output logic              res_done,
  output tt_pkg::res_t      res
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EVAL  = 3'b100
  } state_t;

  state_t               state;
  tt_pkg::entry_t       mem [TABLE_ENTRIES];
  tt_pkg::entry_t       rd_data;
  tt_pkg::entry_t       wr_data;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [IDX_W-1:0]     clr_addr;
  tt_pkg::req_t         cur;
  tt_pkg::res_t         res_eval;
  logic                 hit;
  logic                 is_probe;

  assign clearing = state == ST_CLEAR;
  assign pop      = (state == ST_IDLE) && head_valid;
  assign is_probe = (head_req.action == tt_pkg::ACT_PROBE_SCORE) ||
                    (head_req.action == tt_pkg::ACT_PROBE_MOVE);

  assign wr_en   = clearing || (pop && head_req.action == tt_pkg::ACT_SAVE);
  assign wr_addr = clearing ? clr_addr : head_idx;

  always_comb begin
    wr_data = '0;
    if (!clearing) begin
      wr_data.valid   = 1'b1;
      wr_data.tag     = head_req.key;
      wr_data.depth   = head_req.depth;
      wr_data.bound   = head_req.bound;
      wr_data.score   = head_req.score;
      wr_data.from_sq = head_req.from_sq;
      wr_data.to_sq   = head_req.to_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[head_idx];
  end

  assign hit = rd_data.valid && (rd_data.tag == cur.key);

  always_comb begin
    res_eval = '0;
    case (cur.action)
      tt_pkg::ACT_PROBE_SCORE: begin
        if (hit && rd_data.depth >= cur.depth) begin
          case (rd_data.bound)
            tt_pkg::BOUND_EXACT: begin
              res_eval.score_found = 1'b1;
              res_eval.found_score = rd_data.score;
            end
            tt_pkg::BOUND_UPPER: begin
              if ($signed(rd_data.score) <= $signed(cur.alpha)) begin
                res_eval.score_found = 1'b1;
                res_eval.found_score = cur.alpha;
              end
            end
            tt_pkg::BOUND_LOWER: begin
              if ($signed(rd_data.score) >= $signed(cur.beta)) begin
                res_eval.score_found = 1'b1;
                res_eval.found_score = cur.beta;
              end
            end
            default: ;
          endcase
        end
      end
      tt_pkg::ACT_PROBE_MOVE: begin
        res_eval.move_matches = hit && (rd_data.from_sq == cur.from_sq) &&
                                (rd_data.to_sq == cur.to_sq);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      res_done <= 1'b0;
    end else begin
      res_done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_W'(TABLE_ENTRIES - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (pop) begin
            cur <= head_req;
            if (is_probe) begin
              state <= ST_EVAL;
            end else begin
              res_done <= 1'b1;
              res      <= '0;
            end
          end
        end
        ST_EVAL: begin
          res_done <= 1'b1;
          res      <= res_eval;
          state    <= ST_IDLE;
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  `ASSERT_NEXT(bk_probe_eval_a, pop && is_probe, state == ST_EVAL)
  `ASSERT_NEXT(bk_eval_result_a, state == ST_EVAL, res_done && state == ST_IDLE)

endmodule

// ----- hdl/transposition_table.sv -----
// top level of the direct-mapped, always-replace transposition table
//
// one command channel: an item transfers on a rising edge with start high and busy low.
// action 0 probes a score, 1 saves an entry, 2 probes a best move; each item gives
// exactly one result, shown for one cycle with done high. the receiver cannot stall.
// an item passes the front-end register and the queue to the back end; a probe also
// takes the ST_EVAL state for the registered table read. when TABLE_ENTRIES is not a
// power of two the front end first reduces the key 4 bits per cycle and takes no new
// item until that key is reduced and pushed. otherwise the front end takes an item a
// cycle while its two-entry queue has room; the back end retires a save each cycle
// and takes no new item while it evaluates a probe, since the table memory has a
// registered read port beside its separate write port. after reset the back end
// walks the table once, clearing each entry's valid bit, one entry per cycle, with
// busy high meanwhile. entries never written after that miss every probe.
`include "assert_macros.svh"

module transposition_table #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [tt_pkg::ACT_W-1:0]          action,
  input  logic [tt_pkg::KEY_W-1:0]          position_key,
  input  logic [tt_pkg::DEPTH_W-1:0]        search_depth,
  input  logic signed [tt_pkg::SCORE_W-1:0] alpha_bound,
  input  logic signed [tt_pkg::SCORE_W-1:0] beta_bound,
  input  logic signed [tt_pkg::SCORE_W-1:0] save_score,
  input  logic [tt_pkg::BOUND_W-1:0]        bound_kind,
  input  logic [tt_pkg::SQ_W-1:0]           move_from,
  input  logic [tt_pkg::SQ_W-1:0]           move_to,
  output logic                              done,
  output logic                              score_found,
  output logic signed [tt_pkg::SCORE_W-1:0] found_score,
  output logic                              move_matches
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  tt_pkg::req_t      in_req;
  tt_pkg::req_t      push_req;
  tt_pkg::req_t      head_req;
  tt_pkg::res_t      res;
  logic [IDX_W-1:0]  push_idx;
  logic [IDX_W-1:0]  head_idx;
  logic              accept;
  logic              front_ready;
  logic              push_valid;
  logic              push_ready;
  logic              head_valid;
  logic              pop;
  logic              clearing;

  always_comb begin
    in_req.action  = action;
    in_req.key     = position_key;
    in_req.depth   = search_depth;
    in_req.alpha   = alpha_bound;
    in_req.beta    = beta_bound;
    in_req.score   = save_score;
    in_req.bound   = bound_kind;
    in_req.from_sq = move_from;
    in_req.to_sq   = move_to;
  end

  assign busy   = clearing || !front_ready;
  assign accept = start && !busy;

  tt_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_req      (in_req),
    .front_ready (front_ready),
    .push_valid  (push_valid),
    .push_req    (push_req),
    .push_idx    (push_idx),
    .push_ready  (push_ready)
  );

  tt_queue #(
    .IDX_W (IDX_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_req   (push_req),
    .push_idx   (push_idx),
    .push_ready (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_req   (head_req),
    .head_idx   (head_idx)
  );

  tt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_req   (head_req),
    .head_idx   (head_idx),
    .pop        (pop),
    .clearing   (clearing),
    .res_done   (done),
    .res        (res)
  );

  assign score_found  = res.score_found;
  assign found_score  = res.found_score;
  assign move_matches = res.move_matches;

  `ASSERT_NEVER(tt_no_result_in_clear_a, clearing && done)

endmodule

// ----- bench/transposition_table_tb.sv -----
// self-checking testbench of the transposition table: directed table, then random commands
module transposition_table_tb;

  localparam int TBL_SIZE = 1024;
  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [tt_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [tt_pkg::BOUND_W-1:0] BOUND_UNUSED = 2'd3;
  localparam logic [tt_pkg::KEY_W-1:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    tt_pkg::req_t c;
    bit           pinned;
    tt_pkg::res_t want;
  } step_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic done;
  logic score_found;
  logic signed [tt_pkg::SCORE_W-1:0] found_score;
  logic move_matches;
  tt_pkg::req_t cmd;
  bit           pin_valid;
  tt_pkg::res_t pin_res;

  tt_pkg::entry_t shadow_entries [TBL_SIZE];
  tt_pkg::res_t   awaited_results [$];
  logic [tt_pkg::KEY_W-1:0] hot_keys [16];
  step_t  plan [25];
  int errors = 0;
  int cycles = 0;
  int n_items = 0;
  int n_saves = 0;
  int n_score_hits = 0;
  int n_move_hits = 0;

  transposition_table #(.TABLE_ENTRIES(TBL_SIZE)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(cmd.action),
    .position_key(cmd.key),
    .search_depth(cmd.depth),
    .alpha_bound(cmd.alpha),
    .beta_bound(cmd.beta),
    .save_score(cmd.score),
    .bound_kind(cmd.bound),
    .move_from(cmd.from_sq),
    .move_to(cmd.to_sq),
    .done(done),
    .score_found(score_found),
    .found_score(found_score),
    .move_matches(move_matches)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // applies one command to the shadow table and returns the result it should give
  function automatic tt_pkg::res_t access_shadow(input tt_pkg::req_t c);
    tt_pkg::res_t r;
    int idx;
    tt_pkg::entry_t e;
    logic signed [tt_pkg::SCORE_W-1:0] s, a, b;
    bit hit;
    r = '0;
    idx = int'(c.key % 64'(TBL_SIZE));
    e = shadow_entries[idx];
    hit = e.valid && e.tag == c.key;
    s = e.score;
    a = c.alpha;
    b = c.beta;
    case (c.action)
      tt_pkg::ACT_PROBE_SCORE: begin
        if (hit && e.depth >= c.depth) begin
          if (e.bound == tt_pkg::BOUND_EXACT) begin
            r.score_found = 1'b1;
            r.found_score = s;
          end else if (e.bound == tt_pkg::BOUND_UPPER && s <= a) begin
            r.score_found = 1'b1;
            r.found_score = a;
          end else if (e.bound == tt_pkg::BOUND_LOWER && s >= b) begin
            r.score_found = 1'b1;
            r.found_score = b;
          end
        end
      end
      tt_pkg::ACT_SAVE: begin
        shadow_entries[idx] = '{valid: 1'b1, tag: c.key, depth: c.depth, bound: c.bound,
                                score: c.score, from_sq: c.from_sq, to_sq: c.to_sq};
      end
      tt_pkg::ACT_PROBE_MOVE: begin
        r.move_matches = hit && e.from_sq == c.from_sq && e.to_sq == c.to_sq;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("[%0d] mismatch on %s: expected %0h, got %0h", cycles, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    tt_pkg::res_t r;
    tt_pkg::res_t w;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", awaited_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (!rst) begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", 64'd0,
                          64'({score_found, found_score, move_matches}));
        end else begin
          w = awaited_results.pop_front();
          if (score_found !== w.score_found)
            report_mismatch("score_found", 64'(w.score_found), 64'(score_found));
          if (found_score !== w.found_score)
            report_mismatch("found_score", 64'(w.found_score),
                            64'($unsigned(found_score)));
          if (move_matches !== w.move_matches)
            report_mismatch("move_matches", 64'(w.move_matches), 64'(move_matches));
        end
      end
      if (start && !busy) begin
        r = access_shadow(cmd);
        n_items++;
        if (cmd.action == tt_pkg::ACT_SAVE) n_saves++;
        if (r.score_found) n_score_hits++;
        if (r.move_matches) n_move_hits++;
        awaited_results.push_back(pin_valid ? pin_res : r);
      end
    end
  end

  function automatic step_t mk(input logic [tt_pkg::ACT_W-1:0] act,
                               input logic [tt_pkg::KEY_W-1:0] key,
                               input logic [tt_pkg::DEPTH_W-1:0] depth,
                               input logic signed [tt_pkg::SCORE_W-1:0] alpha,
                               input logic signed [tt_pkg::SCORE_W-1:0] beta,
                               input logic signed [tt_pkg::SCORE_W-1:0] score,
                               input logic [tt_pkg::BOUND_W-1:0] bound,
                               input logic [tt_pkg::SQ_W-1:0] from_sq,
                               input logic [tt_pkg::SQ_W-1:0] to_sq,
                               input bit pinned, input logic found,
                               input logic signed [tt_pkg::SCORE_W-1:0] fscore,
                               input logic match);
    step_t s;
    s.c = '{action: act, key: key, depth: depth, alpha: alpha, beta: beta, score: score,
            bound: bound, from_sq: from_sq, to_sq: to_sq};
    s.pinned = pinned;
    s.want = '{score_found: found, found_score: fscore, move_matches: match};
    return s;
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic tt_pkg::req_t random_command();
    tt_pkg::req_t c;
    tt_pkg::entry_t e;
    int r;
    r = $urandom_range(99);
    c.action = r < 35 ? tt_pkg::ACT_SAVE : r < 70 ? tt_pkg::ACT_PROBE_SCORE
               : r < 95 ? tt_pkg::ACT_PROBE_MOVE : ACT_UNUSED;
    c.key = $urandom_range(9) < 8 ? hot_keys[$urandom_range(15)] : {$urandom, $urandom};
    c.depth = $urandom_range(9) < 7 ? tt_pkg::DEPTH_W'($urandom_range(15))
              : tt_pkg::DEPTH_W'($urandom);
    c.alpha = tt_pkg::SCORE_W'($urandom);
    c.beta = tt_pkg::SCORE_W'($urandom);
    c.score = tt_pkg::SCORE_W'($urandom);
    c.bound = $urandom_range(9) == 0 ? BOUND_UNUSED : tt_pkg::BOUND_W'($urandom_range(2));
    c.from_sq = tt_pkg::SQ_W'($urandom);
    c.to_sq = tt_pkg::SQ_W'($urandom);
    e = shadow_entries[int'(c.key % 64'(TBL_SIZE))];
    if (e.valid && e.tag == c.key) begin
      // steer probes onto the stored entry so hits and near misses are common
      if (c.action == tt_pkg::ACT_PROBE_SCORE && $urandom_range(9) < 7) begin
        c.depth = e.depth + tt_pkg::DEPTH_W'($urandom_range(2)) - tt_pkg::DEPTH_W'(1);
        c.alpha = e.score + tt_pkg::SCORE_W'($urandom_range(2)) - tt_pkg::SCORE_W'(1);
        c.beta = e.score + tt_pkg::SCORE_W'($urandom_range(2)) - tt_pkg::SCORE_W'(1);
      end
      if (c.action == tt_pkg::ACT_PROBE_MOVE && $urandom_range(9) < 6) begin
        c.from_sq = e.from_sq;
        c.to_sq = $urandom_range(4) == 0 ? tt_pkg::SQ_W'($urandom) : e.to_sq;
      end
    end
    return c;
  endfunction

  task automatic issue_command(input tt_pkg::req_t c, input bit pinned,
                               input tt_pkg::res_t want);
    @(negedge clk);
    cmd <= c;
    start <= 1'b1;
    pin_valid <= pinned;
    pin_res <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_commands(input int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      cmd.key <= {$urandom, $urandom};
      cmd.action <= tt_pkg::ACT_W'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    pin_valid <= 1'b0;
    pin_res <= '0;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;
    foreach (hot_keys[i]) begin
      hot_keys[i] = {$urandom, $urandom};
      if (i % 4 == 0) hot_keys[i][9:0] = 10'h155;
    end

    plan[0]  = mk(tt_pkg::ACT_PROBE_SCORE, 64'd0, 8'd0, -16'sd32768, 16'sd32767, 16'sd0,
                  tt_pkg::BOUND_EXACT, 6'd0, 6'd0, 1, 1'b0, 16'sd0, 1'b0);
    plan[1]  = mk(tt_pkg::ACT_PROBE_MOVE, 64'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0,
                  tt_pkg::BOUND_EXACT, 6'd0, 6'd0, 1, 1'b0, 16'sd0, 1'b0);
    plan[2]  = mk(tt_pkg::ACT_SAVE, KEY_ONES, 8'd255, 16'sd0, 16'sd0, -16'sd32768,
                  tt_pkg::BOUND_EXACT, 6'd63, 6'd63, 1, 1'b0, 16'sd0, 1'b0);
    plan[3]  = mk(tt_pkg::ACT_PROBE_SCORE, KEY_ONES, 8'd255, 16'sd0, 16'sd0, 16'sd0,
                  tt_pkg::BOUND_EXACT, 6'd0, 6'd0, 1, 1'b1, -16'sd32768, 1'b0);
    plan[4]  = mk(tt_pkg::ACT_PROBE_MOVE, KEY_ONES, 8'd0, 16'sd0, 16'sd0, 16'sd0,
                  tt_pkg::BOUND_EXACT, 6'd63, 6'd63, 1, 1'b0, 16'sd0, 1'b1);
    plan[5]  = mk(tt_pkg::ACT_PROBE_MOVE, KEY_ONES, 8'd0, 16'sd0, 16'sd0, 16'sd0,
                  tt_pkg::BOUND_EXACT, 6'd63, 6'd0, 1, 1'b0, 16'sd0, 1'b0);
    plan[6]  = mk(tt_pkg::ACT_PROBE_SCORE, 64'h7FFF_FFFF_FFFF_FFFF, 8'd0, 16'sd0, 16'sd0,
                  16'sd0, tt_pkg::BOUND_EXACT, 6'd0, 6'd0, 1, 1'b0, 16'sd0, 1'b0);
    plan[7]  = mk(tt_pkg::ACT_SAVE, 64'd0, 8'd0, 16'sd0, 16'sd0, 16'sd32767,
                  tt_pkg::BOUND_EXACT, 6'd0, 6'd0, 1, 1'b0, 16'sd0, 1'b0);
    plan[8]  = mk(tt_pkg::ACT_PROBE_SCORE, 64'd0, 8'd1, 16'sd0, 16'sd0, 16'sd0,
                  tt_pkg::BOUND_EXACT, 6'd0, 6'd0, 1, 1'b0, 16'sd0, 1'b0);
    plan[9]  = mk(tt_pkg::ACT_PROBE_SCORE, 64'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0,
                  tt_pkg::BOUND_EXACT, 6'd0, 6'd0, 1, 1'b1, 16'sd32767, 1'b0);
    plan[10] = mk(tt_pkg::ACT_PROBE_SCORE, 64'd1024, 8'd0, 16'sd0, 16'sd0, 16'sd0,
                  tt_pkg::BOUND_EXACT, 6'd0, 6'd0, 1, 1'b0, 16'sd0, 1'b0);
    plan[11] = mk(tt_pkg::ACT_SAVE, 64'd5, 8'd10, 16'sd0, 16'sd0, 16'sd100,
                  tt_pkg::BOUND_UPPER, 6'd12, 6'd28, 0, 1'b0, 16'sd0, 1'b0);
    plan[12] = mk(tt_pkg::ACT_PROBE_SCORE, 64'd5, 8'd10, 16'sd100, 16'sd200, 16'sd0,
                  tt_pkg::BOUND_EXACT, 6'd0, 6'd0, 0, 1'b0, 16'sd0, 1'b0);
    plan[13] = mk(tt_pkg::ACT_PROBE_SCORE, 64'd5, 8'd9, 16'sd99, 16'sd200, 16'sd0,
                  tt_pkg::BOUND_EXACT, 6'd0, 6'd0, 0, 1'b0, 16'sd0, 1'b0);
    plan[14] = mk(tt_pkg::ACT_SAVE, 64'd6, 8'd3, 16'sd0, 16'sd0, -16'sd100,
                  tt_pkg::BOUND_LOWER, 6'd1, 6'd2, 0, 1'b0, 16'sd0, 1'b0);
    plan[15] = mk(tt_pkg::ACT_PROBE_SCORE, 64'd6, 8'd0, -16'sd300, -16'sd100, 16'sd0,
                  tt_pkg::BOUND_EXACT, 6'd0, 6'd0, 0, 1'b0, 16'sd0, 1'b0);
    plan[16] = mk(tt_pkg::ACT_PROBE_SCORE, 64'd6, 8'd0, -16'sd300, -16'sd99, 16'sd0,
                  tt_pkg::BOUND_EXACT, 6'd0, 6'd0, 0, 1'b0, 16'sd0, 1'b0);
    plan[17] = mk(tt_pkg::ACT_SAVE, 64'd7, 8'd20, 16'sd0, 16'sd0, 16'sd0,
                  BOUND_UNUSED, 6'd33, 6'd44, 0, 1'b0, 16'sd0, 1'b0);
    plan[18] = mk(tt_pkg::ACT_PROBE_SCORE, 64'd7, 8'd0, 16'sd32767, -16'sd32768, 16'sd0,
                  tt_pkg::BOUND_EXACT, 6'd0, 6'd0, 0, 1'b0, 16'sd0, 1'b0);
    plan[19] = mk(ACT_UNUSED, 64'd7, 8'd0, 16'sd0, 16'sd0, 16'sd0,
                  tt_pkg::BOUND_EXACT, 6'd0, 6'd0, 1, 1'b0, 16'sd0, 1'b0);
    plan[20] = mk(tt_pkg::ACT_PROBE_MOVE, 64'd7, 8'd0, 16'sd0, 16'sd0, 16'sd0,
                  tt_pkg::BOUND_EXACT, 6'd33, 6'd44, 0, 1'b0, 16'sd0, 1'b0);
    plan[21] = mk(tt_pkg::ACT_SAVE, 64'd8, 8'd1, 16'sd0, 16'sd0, 16'sd0,
                  tt_pkg::BOUND_UPPER, 6'd5, 6'd6, 0, 1'b0, 16'sd0, 1'b0);
    plan[22] = mk(tt_pkg::ACT_PROBE_SCORE, 64'd8, 8'd1, 16'sd32767, -16'sd32768, 16'sd0,
                  tt_pkg::BOUND_EXACT, 6'd0, 6'd0, 0, 1'b0, 16'sd0, 1'b0);
    plan[23] = mk(tt_pkg::ACT_SAVE, 64'd9, 8'd1, 16'sd0, 16'sd0, 16'sd0,
                  tt_pkg::BOUND_LOWER, 6'd7, 6'd8, 0, 1'b0, 16'sd0, 1'b0);
    plan[24] = mk(tt_pkg::ACT_PROBE_SCORE, 64'd9, 8'd1, 16'sd32767, -16'sd32768, 16'sd0,
                  tt_pkg::BOUND_EXACT, 6'd0, 6'd0, 0, 1'b0, 16'sd0, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      issue_command(plan[i].c, plan[i].pinned, plan[i].want);
      pause_commands($urandom_range(1) == 0 ? 0 : gap_length());
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      issue_command(random_command(), 1'b0, '0);
      // every third block of 50 transfers runs back to back
      if ((n / 50) % 3 != 2) pause_commands(gap_length());
      if ($urandom_range(19) == 0) hot_keys[$urandom_range(15)] = {$urandom, $urandom};
    end
    pause_commands(1);

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d commands sent (%0d saves) in %0d cycles", n_items, n_saves, cycles);
    $display("%0d score probe hits and %0d move matches predicted, %0d errors",
             n_score_hits, n_move_hits, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
